// ===== rtl/lruc_pkg.sv =====
`default_nettype none
package lruc_pkg;
  localparam int ENTRIES = 16;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int KEY_BITS = 64;
  localparam int VALUE_BITS = 64;
  localparam int TIME_BITS = 32;
  localparam int EXP_W = TIME_BITS + 1;

  typedef enum logic [2:0] {
    ACT_PUT = 3'd0,
    ACT_GET = 3'd1,
    ACT_ERASE = 3'd2,
    ACT_CONTAINS = 3'd3,
    ACT_CLEAR = 3'd4,
    ACT_TICK = 3'd5
  } action_t;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_SWEEP = 1'b1;

  // one stored entry: key, value and expiry share a memory word
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [VALUE_BITS-1:0] value;
    logic [EXP_W-1:0] expiry;
  } entry_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t wr_data;
  } mem_req_t;
endpackage
`default_nettype wire

// ===== rtl/lruc_entry_ram.sv =====
`default_nettype none
module lruc_entry_ram (
  input  wire logic clk,
  input  wire lruc_pkg::mem_req_t req,
  output lruc_pkg::entry_t rd_data
);
  import lruc_pkg::*;

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/lruc_rank_ram.sv =====
`default_nettype none
module lruc_rank_ram (
  input  wire logic clk,
  input  wire logic rd_en,
  input  wire logic [lruc_pkg::IDX_W-1:0] rd_addr,
  input  wire logic wr_en,
  input  wire logic [lruc_pkg::IDX_W-1:0] wr_addr,
  input  wire logic [lruc_pkg::IDX_W-1:0] wr_data,
  output logic [lruc_pkg::IDX_W-1:0] rd_data
);
  import lruc_pkg::*;

  logic [IDX_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/lru_cache_with_ttl.sv =====
`default_nettype none
// Fully associative 16-entry key/value store with LRU replacement and a
// per-entry time-to-live. An item is taken at a rising edge with start high
// and busy low. busy stays high until out_valid, which marks the result on
// the out_ ports for exactly one cycle. The receiver cannot stall, so the
// result must be captured in that cycle. busy is already low in the strobe
// cycle, so the next item can be taken at the edge that ends it. Write
// configuration only while busy is low. Entries are scanned one per cycle
// through a single read port of the entry memory and of the rank memory.
// Each pass over the 16 entries issues 16 reads, waits for the last
// returning word and then closes the pass. Passes run per action:
//   clear, unused actions, non-sweeping tick   none
//   contains, erase miss, get miss             lookup pass
//   get hit, get of an expired key, erase hit  lookup + rank pass
//   put to a live key                          lookup + rank pass
//   put of a new key                           lookup + rank pass + insert,
//                                              plus eviction pass and drop when full
//   put over an expired copy                   lookup + drop + rank pass + insert,
//                                              plus eviction pass and drop when full
//   sweeping tick                              lookup, then drop + lookup per expired entry
// Valid bits live in flip-flops, so there is no clearing pass after reset.
module lru_cache_with_ttl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic [2:0] in_action,
  input  wire logic [63:0] in_key,
  input  wire logic [63:0] in_value,
  input  wire logic [31:0] in_ttl,
  output logic out_valid,
  output logic out_found,
  output logic [63:0] out_read_value,
  output logic [4:0] out_entry_count,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_miss_count,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [15:0] cfg_data
);
  import lruc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_DECIDE, S_RANK, S_OLD, S_INS, S_DONE
  } state_t;

  // what the rank pass does to every other valid entry
  typedef enum logic [1:0] {
    RK_DROP,   // decrement ranks above rank_ref
    RK_RECENT, // increment ranks below rank_ref, hit entry gets rank 0
    RK_ALL     // increment every rank
  } rank_op_t;

  // what follows after a rank pass
  typedef enum logic [2:0] {
    NX_DONE, NX_INSERT, NX_FULL, NX_FILL, NX_SWEEP
  } next_t;

  state_t state_r;
  rank_op_t rop_r;
  next_t nxt_r;

  logic [4:0] cap_r;
  logic [15:0] swint_r;
  logic [ENTRIES-1:0] valid_r;
  logic [TIME_BITS-1:0] now_r;
  logic [15:0] swcnt_r;
  logic [31:0] hits_r, miss_r;

  logic [2:0] act_r;
  logic [KEY_BITS-1:0] key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [EXP_W-1:0] exp_r;
  logic sweep_r;

  logic [CNT_W-1:0] ptr_r;     // address issued this cycle
  logic rvld_r;                // a read is returning
  logic [IDX_W-1:0] raddr_r;   // address of returning data
  logic hit_r;
  logic hexp_r;                // matched entry was expired
  logic [IDX_W-1:0] hidx_r;
  logic [IDX_W-1:0] rank_ref_r;
  logic full_r;                // insert into a full store, no capacity check
  logic [IDX_W-1:0] best_r;
  logic best_vld_r;
  logic [IDX_W-1:0] best_rank_r;
  logic found_r;
  logic [VALUE_BITS-1:0] rv_r;

  mem_req_t ereq;
  entry_t erd;
  logic rk_re, rk_we;
  logic [IDX_W-1:0] rk_ra, rk_wa, rk_wd, rk_rd;

  lruc_entry_ram u_ent (.clk, .req(ereq), .rd_data(erd));
  lruc_rank_ram u_rank (
    .clk, .rd_en(rk_re), .rd_addr(rk_ra), .wr_en(rk_we), .wr_addr(rk_wa),
    .wr_data(rk_wd), .rd_data(rk_rd)
  );

  logic [CNT_W-1:0] live;
  always_comb begin
    live = '0;
    for (int i = 0; i < ENTRIES; i++) live = live + CNT_W'(valid_r[i]);
  end

  // lowest free slot takes a new entry
  logic [IDX_W-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) if (!valid_r[i]) free_idx = IDX_W'(i);
  end

  logic expired;
  assign expired = erd.expiry < EXP_W'(now_r);
  logic scan_end;
  assign scan_end = ptr_r == CNT_W'(ENTRIES);
  logic pass_done;
  assign pass_done = scan_end && !rvld_r;
  logic [15:0] swcnt_nxt;
  assign swcnt_nxt = swcnt_r + 16'd1;

  // memory port drive: sequential reads from ptr_r, rank write-back in the
  // next cycle at raddr_r, so reads and writes of a pass never collide
  always_comb begin
    ereq = '0;
    ereq.rd_en = (state_r == S_LOOK) && !scan_end;
    ereq.rd_addr = ptr_r[IDX_W-1:0];
    rk_re = (state_r == S_LOOK || state_r == S_RANK || state_r == S_OLD)
            && !scan_end;
    rk_ra = ptr_r[IDX_W-1:0];
    rk_we = 1'b0;
    rk_wa = raddr_r;
    rk_wd = rk_rd;
    if (state_r == S_RANK && rvld_r && valid_r[raddr_r]) begin
      unique case (rop_r)
        RK_DROP: if (rk_rd > rank_ref_r) begin
          rk_we = 1'b1; rk_wd = rk_rd - IDX_W'(1);
        end
        RK_RECENT: if (rk_rd < rank_ref_r && raddr_r != hidx_r) begin
          rk_we = 1'b1; rk_wd = rk_rd + IDX_W'(1);
        end
        default: begin
          rk_we = 1'b1; rk_wd = rk_rd + IDX_W'(1);
        end
      endcase
    end
    // closing cycle of a recency pass: hit entry becomes most recent
    if (state_r == S_RANK && pass_done && rop_r == RK_RECENT) begin
      rk_we = 1'b1; rk_wa = hidx_r; rk_wd = '0;
    end
    // live put hit: rewrite value and expiry in place
    if (state_r == S_DECIDE && !sweep_r && act_r == ACT_PUT && hit_r && !hexp_r) begin
      ereq.wr_en = 1'b1;
      ereq.wr_addr = hidx_r;
      ereq.wr_data = '{key: key_r, value: val_r, expiry: exp_r};
    end
    // new entry into the lowest free slot at rank 0
    if (state_r == S_INS) begin
      ereq.wr_en = 1'b1;
      ereq.wr_addr = free_idx;
      ereq.wr_data = '{key: key_r, value: val_r, expiry: exp_r};
      rk_we = 1'b1; rk_wa = free_idx; rk_wd = '0;
    end
  end

  assign busy = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r <= 5'd16;
      swint_r <= 16'd100;
      valid_r <= '0;
      now_r <= '0;
      swcnt_r <= '0;
      hits_r <= '0;
      miss_r <= '0;
      out_valid <= 1'b0;
      rvld_r <= 1'b0;
      ptr_r <= '0;
      rop_r <= RK_DROP;
      nxt_r <= NX_DONE;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_CAPACITY) cap_r <= cfg_data[4:0];
        else swint_r <= cfg_data;
      end
      rvld_r <= 1'b0;
      raddr_r <= ptr_r[IDX_W-1:0];
      unique case (state_r)
        S_IDLE: if (start) begin
          act_r <= in_action;
          key_r <= in_key;
          val_r <= in_value;
          exp_r <= (in_ttl == '0) ? '1 : EXP_W'(now_r) + EXP_W'(in_ttl);
          hit_r <= 1'b0;
          hexp_r <= 1'b0;
          found_r <= 1'b0;
          rv_r <= '0;
          ptr_r <= '0;
          sweep_r <= 1'b0;
          unique case (in_action)
            ACT_PUT, ACT_GET, ACT_ERASE, ACT_CONTAINS: state_r <= S_LOOK;
            ACT_CLEAR: begin
              valid_r <= '0;
              state_r <= S_DONE;
            end
            ACT_TICK: begin
              if (now_r != '1) now_r <= now_r + TIME_BITS'(1);
              // sweep sees the advanced time
              if (swcnt_nxt >= swint_r) begin
                swcnt_r <= '0;
                sweep_r <= 1'b1;
                state_r <= S_LOOK;
              end else begin
                swcnt_r <= swcnt_nxt;
                state_r <= S_DONE;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_LOOK: begin
          // key match, or first expired entry when sweeping
          if (!scan_end) begin
            ptr_r <= ptr_r + CNT_W'(1);
            rvld_r <= 1'b1;
          end
          if (rvld_r && valid_r[raddr_r] && !hit_r
              && (sweep_r ? expired : (erd.key == key_r))) begin
            hit_r <= 1'b1;
            hidx_r <= raddr_r;
            rank_ref_r <= rk_rd;
            hexp_r <= expired;
            if (act_r == ACT_GET && !expired) rv_r <= erd.value;
          end
          if (pass_done) state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          ptr_r <= '0;
          if (sweep_r) begin
            if (hit_r) begin
              valid_r[hidx_r] <= 1'b0;
              rop_r <= RK_DROP; nxt_r <= NX_SWEEP;
              state_r <= S_RANK;
            end else state_r <= S_DONE;
          end else begin
            unique case (act_r)
              ACT_CONTAINS: begin
                found_r <= hit_r;
                state_r <= S_DONE;
              end
              ACT_ERASE: begin
                found_r <= hit_r;
                if (hit_r) begin
                  valid_r[hidx_r] <= 1'b0;
                  rop_r <= RK_DROP; nxt_r <= NX_DONE;
                  state_r <= S_RANK;
                end else state_r <= S_DONE;
              end
              ACT_GET: begin
                if (hit_r && !hexp_r) begin
                  found_r <= 1'b1;
                  if (hits_r != '1) hits_r <= hits_r + 32'd1;
                  rop_r <= RK_RECENT; nxt_r <= NX_DONE;
                  state_r <= S_RANK;
                end else begin
                  if (miss_r != '1) miss_r <= miss_r + 32'd1;
                  if (hit_r) begin
                    // expired entry is removed on the way
                    valid_r[hidx_r] <= 1'b0;
                    rop_r <= RK_DROP; nxt_r <= NX_DONE;
                    state_r <= S_RANK;
                  end else state_r <= S_DONE;
                end
              end
              default: begin // put
                if (hit_r && !hexp_r) begin
                  // memory rewritten this cycle, then refresh recency
                  rop_r <= RK_RECENT; nxt_r <= NX_DONE;
                  state_r <= S_RANK;
                end else if (hit_r) begin
                  // drop the expired copy, then insert afresh
                  valid_r[hidx_r] <= 1'b0;
                  rop_r <= RK_DROP; nxt_r <= NX_INSERT;
                  state_r <= S_RANK;
                end else if (live == CNT_W'(ENTRIES)) begin
                  // full store: evict least recent first
                  full_r <= 1'b1;
                  best_vld_r <= 1'b0;
                  nxt_r <= NX_FULL;
                  state_r <= S_OLD;
                end else begin
                  full_r <= 1'b0;
                  rop_r <= RK_ALL; nxt_r <= NX_FILL;
                  state_r <= S_RANK;
                end
              end
            endcase
          end
        end
        S_RANK: begin
          if (!scan_end) begin
            ptr_r <= ptr_r + CNT_W'(1);
            rvld_r <= 1'b1;
          end
          if (pass_done) begin
            ptr_r <= '0;
            unique case (nxt_r)
              NX_INSERT: begin
                // store cannot be full after the drop
                full_r <= 1'b0;
                rop_r <= RK_ALL; nxt_r <= NX_FILL;
              end
              NX_FULL: begin
                rop_r <= RK_ALL; nxt_r <= NX_FILL;
              end
              NX_FILL: state_r <= S_INS;
              NX_SWEEP: begin
                hit_r <= 1'b0;
                state_r <= S_LOOK;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_OLD: begin
          // highest rank among valid entries is the least recent
          if (!scan_end) begin
            ptr_r <= ptr_r + CNT_W'(1);
            rvld_r <= 1'b1;
          end
          if (rvld_r && valid_r[raddr_r]
              && (!best_vld_r || rk_rd > best_rank_r)) begin
            best_vld_r <= 1'b1; best_r <= raddr_r; best_rank_r <= rk_rd;
          end
          if (pass_done) begin
            ptr_r <= '0;
            if (best_vld_r) begin
              valid_r[best_r] <= 1'b0;
              rank_ref_r <= best_rank_r;
              rop_r <= RK_DROP;
              state_r <= S_RANK;
            end else state_r <= S_DONE;
          end
        end
        S_INS: begin
          valid_r[free_idx] <= 1'b1;
          ptr_r <= '0;
          if (!full_r && (live + CNT_W'(1)) > cap_r) begin
            // over capacity: evict least recent, possibly the new entry
            best_vld_r <= 1'b0;
            nxt_r <= NX_DONE;
            state_r <= S_OLD;
          end else state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_found <= found_r;
          out_read_value <= rv_r;
          out_entry_count <= 5'(live);
          out_hit_count <= hits_r;
          out_miss_count <= miss_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live <= CNT_W'(ENTRIES)) else $error("live count exceeds entries");
  a_out_only_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DONE)) else $error("stray result strobe");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item not taken");
  a_hits_mono: assert property (@(posedge clk) disable iff (!rst_n)
    hits_r >= $past(hits_r) || $past(!rst_n)) else $error("hit total fell");
`endif
endmodule
`default_nettype wire
